### src/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// S-box function, GF(2^8) doubling and a 128-bit block type.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int KEY_WORDS   = 22;
    localparam int SLOT_W      = 5;
    localparam int ROUNDS      = 10;
    localparam int RND_W       = 4;

    // input beat commands
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ENCRYPT = 1'b1;

    typedef logic [127:0] block_t;

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        gf_double = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [0:255];
        t = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[x];
    endfunction

endpackage

### src/aes_column_cell.sv
// ----------------------------------------------------------------------------
// AES column cell
// Holds one state column; each round takes its shifted-in bytes from the
// neighbors, then substitutes, mixes (not in the last round), adds key column.
// ----------------------------------------------------------------------------
module aes_column_cell (
    input  logic        clk,
    input  logic        load,
    input  logic        step,
    input  logic        last,
    input  logic [31:0] load_col,
    input  logic [31:0] shift_col,
    input  logic [31:0] key_col,
    output logic [31:0] col
);

    logic [31:0] col_reg;
    logic [31:0] col_next;
    logic [7:0]  s0, s1, s2, s3, all;
    logic [31:0] mixed;

    // SubBytes, MixColumns (not in last round), AddRoundKey on shifted column
    always_comb
    begin
        s0 = aes_pkg::sbox(shift_col[31:24]);
        s1 = aes_pkg::sbox(shift_col[23:16]);
        s2 = aes_pkg::sbox(shift_col[15:8]);
        s3 = aes_pkg::sbox(shift_col[7:0]);
        all = s0 ^ s1 ^ s2 ^ s3;
        if (last)
            mixed = {s0, s1, s2, s3};
        else
            mixed = {s0 ^ all ^ aes_pkg::gf_double(s0 ^ s1),
                     s1 ^ all ^ aes_pkg::gf_double(s1 ^ s2),
                     s2 ^ all ^ aes_pkg::gf_double(s2 ^ s3),
                     s3 ^ all ^ aes_pkg::gf_double(s3 ^ s0)};
        col_next = col_reg;
        if (load)
            col_next = load_col ^ key_col;
        else if (step)
            col_next = mixed ^ key_col;
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
    end

    assign col = col_reg;

endmodule

### src/aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// AES-128 block encrypt, top level
// Round-key store, round sequencer and a row of four column cells.
// ----------------------------------------------------------------------------
// An encrypt beat is processed as a key add, then ten rounds, one round per
// cycle in the column cells; the result then sits in the column cells until
// taken. No new beat is accepted while a block is in its rounds or stalled.
// Load beats give no result. Reset clears control state;
// the key store is undefined until loaded.
module aes128_block_encrypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [4:0]  key_slot,
    input  logic [63:0] key_half,
    input  logic [63:0] plain_hi,
    input  logic [63:0] plain_lo,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] cipher_hi,
    output logic [63:0] cipher_lo
);

    logic [63:0] store_reg [0:aes_pkg::KEY_WORDS-1];
    logic        busy_reg, busy_next;
    logic [aes_pkg::RND_W-1:0] rnd_reg, rnd_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept, start, step, last, done;
    logic [127:0] key;
    logic [31:0] col [0:3];
    logic [31:0] shf [0:3];
    logic [31:0] ld  [0:3];
    logic [31:0] kc  [0:3];

    assign in_stall = busy_reg | (out_valid_reg & out_stall);
    assign accept   = in_valid & ~in_stall;
    assign start    = accept & (command != aes_pkg::CMD_LOAD);
    assign step     = busy_reg;
    assign last     = (rnd_reg == 4'(aes_pkg::ROUNDS));
    assign done     = busy_reg & last;

    // key store writes
    always_ff @(posedge clk)
    begin
        if (accept && command == aes_pkg::CMD_LOAD && key_slot < 5'(aes_pkg::KEY_WORDS))
            store_reg[key_slot] <= key_half;
    end

    // round key read: round 0 at start, else current round
    always_comb
    begin
        logic [aes_pkg::SLOT_W-1:0] w;
        w = busy_reg ? 5'({rnd_reg, 1'b0}) : 5'd0;
        key = {store_reg[w], store_reg[w + 5'd1]};
    end

    // sequencer
    always_comb
    begin
        busy_next = busy_reg;
        rnd_next  = rnd_reg;
        out_valid_next = out_valid_reg & out_stall;
        if (start)
        begin
            busy_next = 1'b1;
            rnd_next  = 4'd1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
            out_valid_next = 1'b1;
        end
        else if (busy_reg)
            rnd_next = rnd_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ShiftRows wiring between neighbor cells
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            shf[c] = {col[c][31:24], col[(c+1)%4][23:16],
                      col[(c+2)%4][15:8], col[(c+3)%4][7:0]};
            kc[c]  = key[127-32*c -: 32];
        end
        ld[0] = plain_hi[63:32];
        ld[1] = plain_hi[31:0];
        ld[2] = plain_lo[63:32];
        ld[3] = plain_lo[31:0];
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_cell
        aes_column_cell u_cell (
            .clk       (clk),
            .load      (start),
            .step      (step),
            .last      (last),
            .load_col  (ld[g]),
            .shift_col (shf[g]),
            .key_col   (kc[g]),
            .col       (col[g])
        );
    end

    // ciphertext is held in the column cells after the final round
    assign out_valid = out_valid_reg;
    assign cipher_hi = {col[0], col[1]};
    assign cipher_lo = {col[2], col[3]};

endmodule

### tb/aes128_checker.sv
// ----------------------------------------------------------------------------
// AES-128 encrypt checker
// Watches the input and output channels, keeps its own copy of the round-key
// store, computes the ciphertext of every accepted encrypt beat and compares
// each accepted output beat with the oldest pending ciphertext.
// ----------------------------------------------------------------------------
module aes128_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        command,
    input  logic [4:0]  key_slot,
    input  logic [63:0] key_half,
    input  logic [63:0] plain_hi,
    input  logic [63:0] plain_lo,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] cipher_hi,
    input  logic [63:0] cipher_lo,
    output int          fail_count,
    output int          pending
);

    logic [7:0]   sub_lut [0:255];
    logic [63:0]  key_words [0:aes_pkg::KEY_WORDS-1];
    logic [127:0] cipher_queue [$];

    // GF(2^8) helpers
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[0]) acc ^= a;
            a = xtime(a);
            b = b >> 1;
        end
        return acc;
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    // S-box built from the field inverse and the affine map
    initial
    begin
        logic [7:0] inv;
        logic [7:0] base;
        int e;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h01;
            base = x[7:0];
            e = 254;
            while (e != 0)
            begin
                if (e & 1) inv = gmul(inv, base);
                base = gmul(base, base);
                e = e >> 1;
            end
            if (x == 0) inv = 8'h00;
            sub_lut[x] = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4)
                         ^ 8'h63;
        end
    end

    function automatic logic [127:0] encrypt_block(input logic [127:0] pt);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] rk;
        logic [127:0] ct;
        for (int i = 0; i < 16; i++) s[i] = pt[127 - 8*i -: 8];
        for (int r = 0; r <= aes_pkg::ROUNDS; r++)
        begin
            if (r > 0)
            begin
                // SubBytes with ShiftRows
                for (int i = 0; i < 16; i++) t[i] = sub_lut[s[(i + 4*(i%4)) % 16]];
                s = t;
                if (r < aes_pkg::ROUNDS)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        all = a0 ^ a1 ^ a2 ^ a3;
                        s[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                        s[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                        s[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                        s[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
                    end
                end
            end
            rk = {key_words[2*r], key_words[2*r+1]};
            for (int i = 0; i < 16; i++) s[i] ^= rk[127 - 8*i -: 8];
        end
        for (int i = 0; i < 16; i++) ct[127 - 8*i -: 8] = s[i];
        return ct;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    assign pending = cipher_queue.size();

    initial
    begin
        fail_count = 0;
        for (int i = 0; i < aes_pkg::KEY_WORDS; i++) key_words[i] = 64'h0;
    end

    // input beats update the key store or queue a ciphertext
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            if (command == aes_pkg::CMD_LOAD)
            begin
                if (key_slot < aes_pkg::KEY_WORDS) key_words[key_slot] = key_half;
            end
            else
                cipher_queue.push_back(encrypt_block({plain_hi, plain_lo}));
        end
    end

    // output beats compared with oldest pending ciphertext
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cipher_queue.size() == 0)
                report_mismatch("unexpected beat, cipher_hi", cipher_hi, 64'h0);
            else
            begin
                want = cipher_queue.pop_front();
                if (cipher_hi !== want[127:64]) report_mismatch("cipher_hi", cipher_hi, want[127:64]);
                if (cipher_lo !== want[63:0]) report_mismatch("cipher_lo", cipher_lo, want[63:0]);
            end
        end
    end
endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// AES-128 encrypt testbench
// Loads round keys, encrypts directed and random blocks through several
// idle and stall phases, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb;

    localparam int   WATCH_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [4:0]  key_slot;
    logic [63:0] key_half;
    logic [63:0] plain_hi;
    logic [63:0] plain_lo;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;

    aes128_block_encrypt DUT (.*);
    aes128_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // receiver stall pattern
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // watchdog: cycles with no beat accepted on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(input logic cmd, input logic [4:0] slot, input logic [63:0] kh,
                             input logic [63:0] ph, input logic [63:0] pl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        key_slot <= slot;
        key_half <= kh;
        plain_hi <= ph;
        plain_lo <= pl;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic load_key(input logic [4:0] slot, input logic [63:0] kh);
        send_beat(aes_pkg::CMD_LOAD, slot, kh, rand64(), rand64());
    endtask

    task automatic encrypt(input logic [63:0] ph, input logic [63:0] pl);
        send_beat(aes_pkg::CMD_ENCRYPT, 5'($urandom), rand64(), ph, pl);
    endtask

    task automatic load_all_keys();
        for (int i = 0; i < aes_pkg::KEY_WORDS; i++) load_key(5'(i), rand64());
    endtask

    initial
    begin
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        command = aes_pkg::CMD_LOAD;
        key_slot = '0;
        key_half = '0;
        plain_hi = '0;
        plain_lo = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: FIPS-197 appendix C.1 expanded key, then extremes
        load_key(5'd0,  64'h0001020304050607); load_key(5'd1,  64'h08090a0b0c0d0e0f);
        load_key(5'd2,  64'hd6aa74fdd2af72fa); load_key(5'd3,  64'hdaa678f1d6ab76fe);
        load_key(5'd4,  64'hb692cf0b643dbdf1); load_key(5'd5,  64'hbe9bc5006830b3fe);
        load_key(5'd6,  64'hb6ff744ed2c2c9bf); load_key(5'd7,  64'h6c590cbf0469bf41);
        load_key(5'd8,  64'h47f7f7bc95353e03); load_key(5'd9,  64'hf96c32bcfd058dfd);
        load_key(5'd10, 64'h3caaa3e8a99f9deb); load_key(5'd11, 64'h50f3af57adf622aa);
        load_key(5'd12, 64'h5e390f7df7a69296); load_key(5'd13, 64'ha7553dc10aa31f6b);
        load_key(5'd14, 64'h14f9701ae35fe28c); load_key(5'd15, 64'h440adf4d4ea9c026);
        load_key(5'd16, 64'h47438735a41c65b9); load_key(5'd17, 64'he016baf4aebf7ad2);
        load_key(5'd18, 64'h549932d1f0855768); load_key(5'd19, 64'h1093ed9cbe2c974e);
        load_key(5'd20, 64'h13111d7fe3944a17); load_key(5'd21, 64'hf307a78b4d2b30c5);
        encrypt(64'h0011223344556677, 64'h8899aabbccddeeff);
        encrypt(64'h0, 64'h0);
        encrypt('1, '1);
        // out-of-range slots are ignored
        load_key(5'd22, '1);
        load_key(5'd31, '0);
        encrypt(64'h8000000000000001, 64'h0123456789abcdef);

        // random phases: none, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 53 : (phase == 3) ? 9 : 0;
            recv_stall_pct = (phase == 2) ? 53 : (phase == 3) ? 9 : 0;
            load_all_keys();
            n = 0;
            while (n < 120)
            begin
                case ($urandom_range(9))
                    0: load_key(5'($urandom_range(31)), rand64());
                    1: load_key(5'($urandom_range(aes_pkg::KEY_WORDS - 1)), rand64());
                    default:
                    begin
                        encrypt(rand64(), rand64());
                        n++;
                    end
                endcase
            end
        end
        // all-ones and all-zero keys
        recv_stall_pct = 0;
        send_idle_pct = 0;
        for (int i = 0; i < aes_pkg::KEY_WORDS; i++) load_key(5'(i), '1);
        encrypt(rand64(), rand64());
        for (int i = 0; i < aes_pkg::KEY_WORDS; i++) load_key(5'(i), '0);
        encrypt(rand64(), rand64());

        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
